// ===== rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5 package
// shared types, constants and round tables of the md5 engine
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    // command from controller to datapath
    typedef struct packed {
        logic       wr_en;      // write buffer byte
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
        logic       cnt_inc;    // add 8 to bit count
        logic       blk_start;  // load working regs from chaining words
        logic       round_en;   // run one round
        logic [5:0] round_idx;
        logic       blk_finish; // add working regs into chaining words
        logic       reinit;     // back to initial values
        logic [1:0] out_sel;
    } md5_cmd_t;

    typedef struct packed {
        logic [5:0] byte_idx;   // bit count bits 8:3
    } md5_sts_t;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word index used by round r
    function automatic logic [3:0] round_g(input logic [5:0] r);
        logic [3:0] g;
        case (r[5:4])
            2'd0: g = r[3:0];
            2'd1: g = 4'(r[3:0] * 4'd5 + 4'd1);
            2'd2: g = 4'(r[3:0] * 4'd3 + 4'd5);
            default: g = 4'(r[3:0] * 4'd7);
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/md5_stream_if.sv =====
// ----------------------------------------------------------------------------
// md5 stream interface
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface md5_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/md5_datapath.sv =====
// ----------------------------------------------------------------------------
// md5 datapath
// block buffer memory, round unit, chaining words and bit count
// ----------------------------------------------------------------------------
module md5_datapath
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  md5_cmd_t    cmd,
    output md5_sts_t    sts,
    output logic [63:0] bit_count,
    output logic [31:0] digest_word
);

    logic [31:0] buf_mem [16];   // 16 little-endian words
    logic [31:0] rd_word_reg;
    logic [31:0] cv_reg [4];
    logic [31:0] cv_next [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [63:0] cnt_reg;
    logic [31:0] f, t, rot;
    logic [4:0]  s;

    assign sts.byte_idx = cnt_reg[8:3];
    assign bit_count    = cnt_reg;

    // byte writes into word memory, one round word read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            buf_mem[cmd.wr_addr[5:2]][8*cmd.wr_addr[1:0] +: 8] <= cmd.wr_data;
        end
        if (cmd.blk_start)
        begin
            rd_word_reg <= buf_mem[round_g(6'd0)];
        end
        else
        begin
            rd_word_reg <= buf_mem[round_g(cmd.round_idx + 6'd1)];
        end
    end

    always_comb
    begin
        case (cmd.round_idx[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        s   = round_s(cmd.round_idx);
        t   = a_reg + f + rd_word_reg + round_k(cmd.round_idx);
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
        for (int i = 0; i < 4; i++)
        begin
            cv_next[i] = cv_reg[i];
        end
        if (cmd.blk_finish)
        begin
            cv_next[0] = cv_reg[0] + a_reg;
            cv_next[1] = cv_reg[1] + b_reg;
            cv_next[2] = cv_reg[2] + c_reg;
            cv_next[3] = cv_reg[3] + d_reg;
        end
    end

    assign digest_word = cv_reg[cmd.out_sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= INIT_A;
            cv_reg[1] <= INIT_B;
            cv_reg[2] <= INIT_C;
            cv_reg[3] <= INIT_D;
            cnt_reg   <= '0;
        end
        else if (cmd.reinit)
        begin
            cv_reg[0] <= INIT_A;
            cv_reg[1] <= INIT_B;
            cv_reg[2] <= INIT_C;
            cv_reg[3] <= INIT_D;
            cnt_reg   <= '0;
        end
        else
        begin
            cv_reg <= cv_next;
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 64'd8;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.blk_start)
        begin
            a_reg <= cv_reg[0];
            b_reg <= cv_reg[1];
            c_reg <= cv_reg[2];
            d_reg <= cv_reg[3];
        end
        else if (cmd.round_en)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
    end

endmodule

// ===== rtl/md5_ctrl.sv =====
// ----------------------------------------------------------------------------
// md5 controller
// sequences byte intake, padding, compression and digest output
// ----------------------------------------------------------------------------
module md5_ctrl
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_present,
    input  logic        in_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_index,
    output logic        out_last,
    input  md5_sts_t    sts,
    input  logic [63:0] bit_count,
    output md5_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_START = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_FIN   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] ptr_reg, ptr_next;       // padding write pointer
    logic [5:0] rnd_reg, rnd_next;
    logic       closing_reg, closing_next; // pad byte still to be written
    logic       last_blk_reg, last_blk_next; // length goes into this block
    logic [1:0] oidx_reg, oidx_next;
    logic [5:0] wi;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_index = oidx_reg;
    assign out_last  = (oidx_reg == 2'd3);

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        rnd_next      = rnd_reg;
        closing_next  = closing_reg;
        last_blk_next = last_blk_reg;
        oidx_next     = oidx_reg;
        cmd           = '0;
        cmd.round_idx = rnd_reg;
        cmd.out_sel   = oidx_reg;
        wi            = sts.byte_idx;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_present)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = wi;
                        cmd.wr_data = in_byte;
                        cmd.cnt_inc = 1'b1;
                        wi          = wi + 6'd1;
                    end
                    closing_next  = in_end;
                    last_blk_next = 1'b0;
                    if (in_present && sts.byte_idx == 6'd63)
                    begin
                        // full block first; if the message ends here, padding follows the round loop
                        state_next = ST_START;
                    end
                    else if (in_end)
                    begin
                        state_next    = ST_PAD;
                        ptr_next      = wi;
                        last_blk_next = (wi < LEN_POS);
                    end
                end
            end
            // one buffer byte per cycle: 0x80, zeros, then length
            ST_PAD:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = ptr_reg;
                ptr_next    = ptr_reg + 6'd1;
                if (closing_reg && ptr_reg == sts.byte_idx)
                begin
                    cmd.wr_data  = PAD_BYTE;
                    closing_next = 1'b0;
                end
                else if (last_blk_reg && ptr_reg >= LEN_POS)
                begin
                    cmd.wr_data = bit_count[8*ptr_reg[2:0] +: 8];
                end
                else
                begin
                    cmd.wr_data = 8'h00;
                end
                if (ptr_reg == 6'd63)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.blk_start = 1'b1;
                rnd_next      = '0;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.blk_finish = 1'b1;
                oidx_next      = '0;
                if (last_blk_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (closing_reg || sts.byte_idx != 6'd0)
                begin
                    // extra block that carries the length
                    state_next    = ST_PAD;
                    ptr_next      = 6'd0;
                    last_blk_next = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    oidx_next = oidx_reg + 2'd1;
                    if (oidx_reg == 2'd3)
                    begin
                        cmd.reinit    = 1'b1;
                        last_blk_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ptr_reg      <= '0;
            rnd_reg      <= '0;
            closing_reg  <= 1'b0;
            last_blk_reg <= 1'b0;
            oidx_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            rnd_reg      <= rnd_next;
            closing_reg  <= closing_next;
            last_blk_reg <= last_blk_next;
            oidx_reg     <= oidx_next;
        end
    end

endmodule

// ===== rtl/md5_hash_engine.sv =====
// ----------------------------------------------------------------------------
// md5 hash engine
// streaming md5 digest, at most one message byte per transfer, digest as four words
// ----------------------------------------------------------------------------
//  channel    dir   payload
//  in_ch      sink  data_byte, byte_present, end_of_message
//  out_ch     src   digest_word, word_index, last_word
//
//  a byte transfer is accepted while the engine is idle; the 64th byte of a block
//  starts the 64-round loop (one round per cycle through a single round unit)
//  message end: byte-serial padding up to the end of the block, then the round
//  loop for each block, one or two blocks, then four transfers
//  input is stalled while a block or the digest is in progress
//  reset is asynchronous; no clearing pass is needed
// ----------------------------------------------------------------------------
module md5_hash_engine
    import md5_pkg::*;
(
    input logic clk,
    input logic rst_n,
    md5_stream_if.sink   in_ch,
    md5_stream_if.source out_ch
);

    md5_cmd_t    cmd;
    md5_sts_t    sts;
    logic [31:0] word;
    logic [63:0] bit_count;
    logic [1:0]  idx;
    logic        last;

    md5_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_byte    (in_ch.payload.data_byte),
        .in_present (in_ch.payload.byte_present),
        .in_end     (in_ch.payload.end_of_message),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_index  (idx),
        .out_last   (last),
        .sts        (sts),
        .bit_count  (bit_count),
        .cmd        (cmd)
    );

    md5_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .bit_count   (bit_count),
        .digest_word (word)
    );

    assign out_ch.payload.digest_word = word;
    assign out_ch.payload.word_index  = idx;
    assign out_ch.payload.last_word   = last;

endmodule

// ===== tb/sv/tb_md5_hash_engine.sv =====
// ----------------------------------------------------------------------------
// md5 hash engine testbench
// streams messages byte by byte, predicts each digest word with a local md5
// model and checks every output transfer against the oldest expected word
// ----------------------------------------------------------------------------
module tb_md5_hash_engine;
    import md5_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } md5_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } md5_out_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 420;
    localparam int QUIET_FROM  = 360;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_AT    = 260;

    class digest_scoreboard;
        bit [31:0] chain[4];
        bit [7:0]  blk[64];
        bit [63:0] msg_bits;
        md5_out_t  digest_q[$];
        int        errors;
        bit [31:0] sine_k[64] = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        int rot_amt[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            chain[0] = INIT_A;
            chain[1] = INIT_B;
            chain[2] = INIT_C;
            chain[3] = INIT_D;
            msg_bits = '0;
        endfunction

        function void compress();
            bit [31:0] w[16];
            bit [31:0] a, b, c, d, f, t;
            int g, q;
            for (int r = 0; r < 16; r++)
                w[r] = {blk[4*r+3], blk[4*r+2], blk[4*r+1], blk[4*r]};
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int r = 0; r < 64; r++)
            begin
                q = r / 16;
                case (q)
                    0:
                    begin
                        f = (b & c) | (~b & d);
                        g = r;
                    end
                    1:
                    begin
                        f = (b & d) | (c & ~d);
                        g = (5 * r + 1) % 16;
                    end
                    2:
                    begin
                        f = b ^ c ^ d;
                        g = (3 * r + 5) % 16;
                    end
                    default:
                    begin
                        f = c ^ (b | ~d);
                        g = (7 * r) % 16;
                    end
                endcase
                t = a + f + w[g] + sine_k[r];
                t = (t << rot_amt[q*4 + r%4]) | (t >> (32 - rot_amt[q*4 + r%4]));
                a = d;
                d = c;
                c = b;
                b = b + t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void note_input(md5_in_t it);
            bit [5:0] pos;
            md5_out_t exp_word;
            pos = msg_bits[8:3];
            if (it.byte_present)
            begin
                blk[pos] = it.data_byte;
                msg_bits += 64'd8;
                if (pos == 6'd63)
                    compress();
                pos = pos + 6'd1;
            end
            if (!it.end_of_message)
                return;
            blk[pos] = PAD_BYTE;
            if (pos >= LEN_POS)
            begin
                for (int k = pos + 1; k < 64; k++)
                    blk[k] = 8'h00;
                compress();
                for (int k = 0; k < 56; k++)
                    blk[k] = 8'h00;
            end
            else
            begin
                for (int k = pos + 1; k < 56; k++)
                    blk[k] = 8'h00;
            end
            for (int k = 0; k < 8; k++)
                blk[56+k] = msg_bits[8*k +: 8];
            compress();
            for (int k = 0; k < 4; k++)
            begin
                exp_word.digest_word = chain[k];
                exp_word.word_index  = 2'(k);
                exp_word.last_word   = (k == 3);
                digest_q.push_back(exp_word);
            end
            restart();
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_result(md5_out_t got);
            md5_out_t want;
            if (digest_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %h", got.digest_word));
                return;
            end
            want = digest_q.pop_front();
            if (got.digest_word !== want.digest_word)
                report_mismatch($sformatf("digest_word %h, want %h",
                                          got.digest_word, want.digest_word));
            if (got.word_index !== want.word_index)
                report_mismatch($sformatf("word_index %0d, want %0d",
                                          got.word_index, want.word_index));
            if (got.last_word !== want.last_word)
                report_mismatch($sformatf("last_word %b, want %b",
                                          got.last_word, want.last_word));
        endtask

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    int   items_sent;
    bit   quiet;
    bit   hold_req;
    digest_scoreboard sb;

    md5_stream_if #(.payload_t(md5_in_t))  in_ch ();
    md5_stream_if #(.payload_t(md5_out_t)) out_ch ();

    md5_hash_engine dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.payload);

    // receiver: random stalls plus one long hold-off so the engine backs up
    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task send_item(input logic [7:0] data, input bit present, input bit last);
        md5_in_t it;
        it.data_byte      = data;
        it.byte_present   = present;
        it.end_of_message = last;
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_input(it);
        if (present || last)
            items_sent++;
        quiet = (items_sent >= QUIET_FROM);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task send_message(input int len);
        bit joined;
        joined = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, joined && (i == len - 1));
        end
        if (!joined)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int len;
        int pick;
        int edge_lens[10] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};
        bit drained;
        bit held;
        sb = new();
        cycles     = 0;
        items_sent = 0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        drained    = 1'b0;
        held       = 1'b0;
        rst_n <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, idle item, byte with end, mixed byte values
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h55, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'h3c, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                len = edge_lens[$urandom_range(0, 9)];
            else
                len = $urandom_range(0, 20);
            if (items_sent >= HOLD_AT && !held)
            begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (items_sent >= DRAIN_AT && !drained)
            begin
                drained = 1'b1;
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            send_message(len);
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
